/* hdl/snmp_rv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNMP request validator package
// Parse phases, BER tags and the record type shared by the parser and the
// top level.
// ----------------------------------------------------------------------------
package snmp_rv_pkg;

    localparam int unsigned DEF_MAX_VARBINDS = 16;
    localparam logic [6:0]  DEF_MAX_COMMUNITY = 7'd8;

    localparam logic [7:0] TAG_INT     = 8'h02;
    localparam logic [7:0] TAG_OCTS    = 8'h04;
    localparam logic [7:0] TAG_NULL    = 8'h05;
    localparam logic [7:0] TAG_OID     = 8'h06;
    localparam logic [7:0] TAG_SEQ     = 8'h30;
    localparam logic [7:0] TAG_GET     = 8'hA0;
    localparam logic [7:0] TAG_GETNEXT = 8'hA1;
    localparam logic [7:0] TAG_SET     = 8'hA3;
    localparam logic [7:0] LONG_LEN_BIT = 8'h80;
    localparam logic [7:0] MAX_OID_VALUE = 8'd50;
    localparam logic [7:0] MAX_OCTS_VALUE = 8'd127;

    localparam logic [1:0] PDU_GET     = 2'd0;
    localparam logic [1:0] PDU_GETNEXT = 2'd1;
    localparam logic [1:0] PDU_SET     = 2'd2;

    typedef enum logic [4:0] {
        P_OUT_TAG, P_OUT_LEN, P_VER_TAG, P_VER_LEN, P_VER_VAL,
        P_COM_TAG, P_COM_LEN, P_COM_BODY, P_PDU_TAG, P_PDU_LEN,
        P_RID_TAG, P_RID_LEN, P_RID_BODY, P_ERR_TAG, P_ERR_LEN, P_ERR_VAL,
        P_EIX_TAG, P_EIX_LEN, P_EIX_VAL, P_VBL_TAG, P_VBL_LEN,
        P_VB_TAG, P_VB_LEN, P_OID_TAG, P_OID_LEN, P_OID_BODY,
        P_VAL_TAG, P_VAL_LEN, P_VAL_BODY
    } phase_t;

    typedef struct packed {
        logic        record_kind;
        logic        accepted;
        logic [1:0]  pdu_kind;
        logic [31:0] msg_id;
        logic [6:0]  community_length;
        logic [4:0]  varbind_number;
        logic [7:0]  oid_offset;
        logic [6:0]  oid_length;
        logic [7:0]  value_tag;
        logic [6:0]  value_length;
        logic        last_of_run;
    } record_t;

    localparam int unsigned RECORD_W = $bits(record_t);

endpackage
`default_nettype wire

/* hdl/snmp_request_validator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNMP request validator
// Checks SNMPv1 request BER layout byte by byte and reports varbinds and a
// verdict per packet.
// ----------------------------------------------------------------------------
// At most one byte is taken per cycle. Each byte is parsed in the cycle it is taken
// and its results (a varbind record, a verdict, or both) go into a two-entry
// output queue, so the first result appears on the master side the cycle
// after its byte. A byte is taken only when the queue is empty or hands over
// its one remaining result in that cycle. With m_tready held high a byte with
// at most one result leaves the slave side ready in the next cycle, so the
// block sustains one byte per cycle; a byte that yields two results (a varbind
// that closes on the last byte) fills the queue and stalls the slave side
// until the first of those results has been taken.
// ----------------------------------------------------------------------------
module snmp_request_validator
    import snmp_rv_pkg::*;
#(
    parameter int unsigned MAX_VARBINDS = DEF_MAX_VARBINDS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // end_of_packet
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,  // max_community_len
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] record_kind [1] accepted [3:2] pdu_kind [35:4] msg_id
    // [42:36] community_length [47:43] varbind_number [55:48] oid_offset
    // [62:56] oid_length [70:63] value_tag [77:71] value_length, zero fill
    output logic [79:0]      m_tdata,
    output logic             m_tlast    // last_of_run
);

    logic [6:0] max_com_reg;
    logic       step;
    record_t    rec_a, rec_b;
    logic       rec_a_valid, rec_b_valid;

    record_t    q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) max_com_reg <= DEF_MAX_COMMUNITY;
        else if (cfg_valid) max_com_reg <= cfg_data;
    end

    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign step     = s_tvalid && s_tready;

    snmp_rv_parser #(.MAX_VARBINDS(MAX_VARBINDS)) u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .data_byte         (s_tdata),
        .end_of_packet     (s_tlast),
        .max_community_len (max_com_reg),
        .rec_a             (rec_a),
        .rec_a_valid       (rec_a_valid),
        .rec_b             (rec_b),
        .rec_b_valid       (rec_b_valid)
    );

    always_comb begin
        cnt_next = cnt_reg - {1'b0, pop} + {1'b0, rec_a_valid} + {1'b0, rec_b_valid};
    end

    // Advance the queue, then append new results behind what remains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) q_reg[0] <= q_reg[1];
        if (step) begin
            if (cnt_reg == 2'd0 || pop) begin
                if (rec_a_valid) begin
                    q_reg[0] <= rec_a;
                    q_reg[1] <= rec_b;
                end else begin
                    q_reg[0] <= rec_b;
                end
            end
        end
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {2'b00, q_reg[0].value_length, q_reg[0].value_tag,
                       q_reg[0].oid_length, q_reg[0].oid_offset,
                       q_reg[0].varbind_number, q_reg[0].community_length,
                       q_reg[0].msg_id, q_reg[0].pdu_kind,
                       q_reg[0].accepted, q_reg[0].record_kind};
    assign m_tlast  = q_reg[0].last_of_run;

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("output queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> cnt_next <= 2'd2)
        else $error("byte taken without room");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rec_b_valid |-> rec_b.last_of_run)
        else $error("verdict not last of run");

endmodule
`default_nettype wire

/* hdl/snmp_rv_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNMP request validator parser
// Per-byte BER state machine; produces up to two records for each byte.
// ----------------------------------------------------------------------------
module snmp_rv_parser
    import snmp_rv_pkg::*;
#(
    parameter int unsigned MAX_VARBINDS = DEF_MAX_VARBINDS
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_packet,
    input  wire logic [6:0] max_community_len,
    output record_t         rec_a,
    output logic            rec_a_valid,
    output record_t         rec_b,
    output logic            rec_b_valid
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  decl_end_reg, decl_end_next;
    logic [7:0]  pdu_end_reg, pdu_end_next;
    logic [7:0]  vb_end_reg, vb_end_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] rid_reg, rid_next;
    logic [6:0]  com_len_reg, com_len_next;
    logic [1:0]  kind_reg, kind_next;
    logic [4:0]  vb_cnt_reg, vb_cnt_next;
    logic [7:0]  oid_off_reg, oid_off_next;
    logic [6:0]  oid_len_reg, oid_len_next;
    logic [6:0]  val_len_reg, val_len_next;
    logic        reject_reg, reject_next;

    logic [8:0]  field_end;
    logic        complete;
    logic        ok;
    logic [7:0]  remain_dec;

    assign field_end  = {1'b0, pos_reg} + 9'd1 + {1'b0, data_byte};
    assign remain_dec = remain_reg - 8'd1;

    always_comb begin
        phase_next    = phase_reg;
        remain_next   = remain_reg;
        decl_end_next = decl_end_reg;
        pdu_end_next  = pdu_end_reg;
        vb_end_next   = vb_end_reg;
        tag_next      = tag_reg;
        rid_next      = rid_reg;
        com_len_next  = com_len_reg;
        kind_next     = kind_reg;
        vb_cnt_next   = vb_cnt_reg;
        oid_off_next  = oid_off_reg;
        oid_len_next  = oid_len_reg;
        val_len_next  = val_len_reg;
        reject_next   = reject_reg;
        complete      = 1'b0;

        if (!reject_reg) begin
            if (phase_reg != P_OUT_TAG && phase_reg != P_OUT_LEN
                    && pos_reg >= decl_end_reg) begin
                reject_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    P_OUT_TAG: if (data_byte != TAG_SEQ) reject_next = 1'b1;
                               else phase_next = P_OUT_LEN;
                    P_OUT_LEN: begin
                        if ((data_byte & LONG_LEN_BIT) != 8'd0) reject_next = 1'b1;
                        else begin
                            decl_end_next = data_byte + 8'd2;
                            phase_next = P_VER_TAG;
                        end
                    end
                    P_VER_TAG: if (data_byte != TAG_INT) reject_next = 1'b1;
                               else phase_next = P_VER_LEN;
                    P_VER_LEN: if (data_byte != 8'd1) reject_next = 1'b1;
                               else phase_next = P_VER_VAL;
                    P_VER_VAL: if (data_byte != 8'd0) reject_next = 1'b1;
                               else phase_next = P_COM_TAG;
                    P_COM_TAG: if (data_byte != TAG_OCTS) reject_next = 1'b1;
                               else phase_next = P_COM_LEN;
                    P_COM_LEN: begin
                        if (data_byte == 8'd0 || data_byte > {1'b0, max_community_len}
                                || field_end > {1'b0, decl_end_reg}) begin
                            reject_next = 1'b1;
                        end else begin
                            com_len_next = data_byte[6:0];
                            remain_next  = data_byte;
                            phase_next   = P_COM_BODY;
                        end
                    end
                    P_COM_BODY: begin
                        remain_next = remain_dec;
                        if (remain_dec == 8'd0) phase_next = P_PDU_TAG;
                    end
                    P_PDU_TAG: begin
                        phase_next = P_PDU_LEN;
                        case (data_byte)
                            TAG_GET:     kind_next = PDU_GET;
                            TAG_GETNEXT: kind_next = PDU_GETNEXT;
                            TAG_SET:     kind_next = PDU_SET;
                            default: begin
                                reject_next = 1'b1;
                                phase_next  = phase_reg;
                            end
                        endcase
                    end
                    P_PDU_LEN: begin
                        if (field_end != {1'b0, decl_end_reg}) reject_next = 1'b1;
                        else begin
                            pdu_end_next = field_end[7:0];
                            phase_next = P_RID_TAG;
                        end
                    end
                    P_RID_TAG: if (data_byte != TAG_INT) reject_next = 1'b1;
                               else phase_next = P_RID_LEN;
                    P_RID_LEN: begin
                        if (data_byte != 8'd4) reject_next = 1'b1;
                        else begin
                            remain_next = 8'd4;
                            phase_next  = P_RID_BODY;
                        end
                    end
                    P_RID_BODY: begin
                        rid_next    = {rid_reg[23:0], data_byte};
                        remain_next = remain_dec;
                        if (remain_dec == 8'd0) phase_next = P_ERR_TAG;
                    end
                    P_ERR_TAG: if (data_byte != TAG_INT) reject_next = 1'b1;
                               else phase_next = P_ERR_LEN;
                    P_ERR_LEN: if (data_byte != 8'd1) reject_next = 1'b1;
                               else phase_next = P_ERR_VAL;
                    P_ERR_VAL: if (data_byte != 8'd0) reject_next = 1'b1;
                               else phase_next = P_EIX_TAG;
                    P_EIX_TAG: if (data_byte != TAG_INT) reject_next = 1'b1;
                               else phase_next = P_EIX_LEN;
                    P_EIX_LEN: if (data_byte != 8'd1) reject_next = 1'b1;
                               else phase_next = P_EIX_VAL;
                    P_EIX_VAL: if (data_byte != 8'd0) reject_next = 1'b1;
                               else phase_next = P_VBL_TAG;
                    P_VBL_TAG: if (data_byte != TAG_SEQ) reject_next = 1'b1;
                               else phase_next = P_VBL_LEN;
                    P_VBL_LEN: if (field_end != {1'b0, pdu_end_reg}) reject_next = 1'b1;
                               else phase_next = P_VB_TAG;
                    P_VB_TAG: begin
                        if (32'(vb_cnt_reg) >= MAX_VARBINDS || data_byte != TAG_SEQ)
                            reject_next = 1'b1;
                        else
                            phase_next = P_VB_LEN;
                    end
                    P_VB_LEN: begin
                        if (field_end > {1'b0, decl_end_reg}) reject_next = 1'b1;
                        else begin
                            vb_end_next = field_end[7:0];
                            phase_next  = P_OID_TAG;
                        end
                    end
                    P_OID_TAG: if (data_byte != TAG_OID) reject_next = 1'b1;
                               else phase_next = P_OID_LEN;
                    P_OID_LEN: begin
                        if (field_end > {1'b0, vb_end_reg}) reject_next = 1'b1;
                        else begin
                            oid_off_next = pos_reg + 8'd1;
                            oid_len_next = data_byte[6:0];
                            val_len_next = 7'd0;
                            remain_next  = data_byte;
                            phase_next   = (data_byte == 8'd0) ? P_VAL_TAG : P_OID_BODY;
                        end
                    end
                    P_OID_BODY: begin
                        remain_next = remain_dec;
                        if (remain_dec == 8'd0) phase_next = P_VAL_TAG;
                    end
                    P_VAL_TAG: begin
                        if (data_byte != TAG_INT && data_byte != TAG_OCTS
                                && data_byte != TAG_NULL && data_byte != TAG_OID) begin
                            reject_next = 1'b1;
                        end else begin
                            tag_next   = data_byte;
                            phase_next = P_VAL_LEN;
                        end
                    end
                    P_VAL_LEN: begin
                        if (field_end != {1'b0, vb_end_reg}
                                || (tag_reg == TAG_INT && data_byte != 8'd1
                                    && data_byte != 8'd2 && data_byte != 8'd4)
                                || (tag_reg == TAG_OID && data_byte > MAX_OID_VALUE)
                                || (tag_reg == TAG_OCTS && data_byte > MAX_OCTS_VALUE)) begin
                            reject_next = 1'b1;
                        end else begin
                            val_len_next = data_byte[6:0];
                            remain_next  = data_byte;
                            if (data_byte == 8'd0) complete = 1'b1;
                            else phase_next = P_VAL_BODY;
                        end
                    end
                    P_VAL_BODY: begin
                        remain_next = remain_dec;
                        if (remain_dec == 8'd0) complete = 1'b1;
                    end
                    default: reject_next = 1'b1;
                endcase
            end
        end

        if (complete) begin
            vb_cnt_next = vb_cnt_reg + 5'd1;
            phase_next  = P_VB_TAG;
        end
    end

    assign pos_next = (pos_reg != 8'hFF) ? pos_reg + 8'd1 : pos_reg;
    assign ok = !reject_next && phase_next == P_VB_TAG
                && ({1'b0, pos_reg} + 9'd1) == {1'b0, decl_end_next};

    // Varbind record carries the count before this varbind; verdict the count after
    always_comb begin
        rec_a = '0;
        rec_a.pdu_kind         = kind_next;
        rec_a.msg_id           = rid_next;
        rec_a.community_length = com_len_next;
        rec_a.varbind_number   = vb_cnt_reg;
        rec_a.oid_offset       = oid_off_next;
        rec_a.oid_length       = oid_len_next;
        rec_a.value_tag        = tag_next;
        rec_a.value_length     = val_len_next;
        rec_a.last_of_run      = !end_of_packet;
        rec_a_valid            = step && complete;

        rec_b = '0;
        rec_b.record_kind = 1'b1;
        rec_b.last_of_run = 1'b1;
        if (ok) begin
            rec_b.accepted         = 1'b1;
            rec_b.pdu_kind         = kind_next;
            rec_b.msg_id           = rid_next;
            rec_b.community_length = com_len_next;
            rec_b.varbind_number   = vb_cnt_next;
        end
        rec_b_valid = step && end_of_packet;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_packet)) begin
            phase_reg    <= P_OUT_TAG;
            pos_reg      <= '0;
            remain_reg   <= '0;
            decl_end_reg <= '0;
            pdu_end_reg  <= '0;
            vb_end_reg   <= '0;
            tag_reg      <= '0;
            rid_reg      <= '0;
            com_len_reg  <= '0;
            kind_reg     <= '0;
            vb_cnt_reg   <= '0;
            oid_off_reg  <= '0;
            oid_len_reg  <= '0;
            val_len_reg  <= '0;
            reject_reg   <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            remain_reg   <= remain_next;
            decl_end_reg <= decl_end_next;
            pdu_end_reg  <= pdu_end_next;
            vb_end_reg   <= vb_end_next;
            tag_reg      <= tag_next;
            rid_reg      <= rid_next;
            com_len_reg  <= com_len_next;
            kind_reg     <= kind_next;
            vb_cnt_reg   <= vb_cnt_next;
            oid_off_reg  <= oid_off_next;
            oid_len_reg  <= oid_len_next;
            val_len_reg  <= val_len_next;
            reject_reg   <= reject_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        reject_reg && step && !end_of_packet |=> reject_reg)
        else $error("reject flag cleared mid packet");
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && end_of_packet |=> phase_reg == P_OUT_TAG && pos_reg == 8'd0)
        else $error("state not cleared after last byte");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rec_a_valid |-> !reject_reg)
        else $error("record emitted after reject");
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(vb_cnt_reg) <= MAX_VARBINDS)
        else $error("varbind count overrun");

endmodule
`default_nettype wire
